// ===== hdl/sbe_pkg.sv =====
// shared types and constants for the stack bytecode evaluator
package sbe_pkg;

	// operand stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	// bytecode opcodes
	localparam logic [7:0] OP_HALT = 8'd0;
	localparam logic [7:0] OP_ADD  = 8'd1;
	localparam logic [7:0] OP_SUB  = 8'd2;
	localparam logic [7:0] OP_MUL  = 8'd3;
	localparam logic [7:0] OP_DIV  = 8'd4;
	localparam logic [7:0] OP_NEG  = 8'd5;
	localparam logic [7:0] OP_LIT  = 8'd6;

	// literal operand length in bytes
	localparam logic [2:0] LIT_BYTES = 3'd4;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_UNBALANCED = 3'd1,
		ST_ILLEGAL    = 3'd2,
		ST_UNDERFLOW  = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_DIVZERO    = 3'd5
	} status_t;

	// shared arithmetic unit operations
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_ALU
	} ctrl_state_t;

	// arithmetic unit states
	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_FIX
	} alu_state_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage

// ===== hdl/sbe_alu.sv =====
// shared arithmetic unit: add, subtract, multiply, bit-serial signed divide
module sbe_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  sbe_pkg::alu_req_t req,
	output sbe_pkg::alu_rsp_t rsp
);

	sbe_pkg::alu_state_t                 astate_q, astate_d;
	logic                                done_q, done_d;
	logic [sbe_pkg::DIV_CNT_W-1:0]       cnt_q, cnt_d;
	logic [sbe_pkg::DATA_W-1:0]          rem_q;
	logic [sbe_pkg::DATA_W-1:0]          quo_q;
	logic [sbe_pkg::DATA_W-1:0]          dvs_q;
	logic                                neg_q;
	logic [sbe_pkg::DATA_W-1:0]          result_q;
	logic [sbe_pkg::DATA_W:0]            shifted;
	logic [sbe_pkg::DATA_W:0]            diff;
	logic                                borrow;

	// one restoring divide step
	assign shifted = {rem_q, quo_q[sbe_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign borrow  = diff[sbe_pkg::DATA_W];

	// control: next state, step counter and done pulse
	always_comb begin
		astate_d = astate_q;
		done_d   = 1'b0;
		cnt_d    = cnt_q;
		case (astate_q)
			sbe_pkg::A_IDLE: begin
				if (req.start) begin
					if (req.op == sbe_pkg::ALU_DIV) begin
						astate_d = sbe_pkg::A_DIV;
						cnt_d    = '0;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			sbe_pkg::A_DIV: begin
				cnt_d = cnt_q + sbe_pkg::DIV_CNT_W'(1);
				if (cnt_q == sbe_pkg::DIV_CNT_W'(sbe_pkg::DATA_W - 1)) begin
					astate_d = sbe_pkg::A_FIX;
				end
			end
			sbe_pkg::A_FIX: begin
				done_d   = 1'b1;
				astate_d = sbe_pkg::A_IDLE;
			end
			default: begin
				astate_d = sbe_pkg::A_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			astate_q <= sbe_pkg::A_IDLE;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			astate_q <= astate_d;
			done_q   <= done_d;
			cnt_q    <= cnt_d;
		end
	end

	// datapath: operand magnitudes, partial remainder, quotient and result
	always_ff @(posedge clk) begin
		case (astate_q)
			sbe_pkg::A_IDLE: begin
				if (req.start) begin
					case (req.op)
						sbe_pkg::ALU_ADD: result_q <= req.a + req.b;
						sbe_pkg::ALU_SUB: result_q <= req.a - req.b;
						sbe_pkg::ALU_MUL: result_q <= req.a * req.b;
						default: begin
							rem_q <= '0;
							quo_q <= req.a[sbe_pkg::DATA_W-1] ?
								(~req.a + sbe_pkg::DATA_W'(1)) : req.a;
							dvs_q <= req.b[sbe_pkg::DATA_W-1] ?
								(~req.b + sbe_pkg::DATA_W'(1)) : req.b;
							neg_q <= req.a[sbe_pkg::DATA_W-1] ^ req.b[sbe_pkg::DATA_W-1];
						end
					endcase
				end
			end
			sbe_pkg::A_DIV: begin
				rem_q <= borrow ? shifted[sbe_pkg::DATA_W-1:0] : diff[sbe_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sbe_pkg::DATA_W-2:0], ~borrow};
			end
			sbe_pkg::A_FIX: begin
				result_q <= neg_q ? (~quo_q + sbe_pkg::DATA_W'(1)) : quo_q;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

// ===== hdl/stack_bytecode_evaluator_unit.sv =====
// top level: byte decoder, operand stack and sequencer around the shared unit
//
// Input channel: one bytecode word per handshake (code_byte, program_start).
// program_start marks the first byte of a program; it clears the stack and
// any error before that byte is decoded. Output channel: one word (value,
// status) per HALT or fault; value is 0 whenever status is not ok.
// Steps per input word, set by the sequencer and the shared arithmetic unit:
//   literal bytes, LIT, HALT, faults and ignored bytes: handled when accepted
//   NEG: unit issue, result write-back
//   ADD, SUB, MUL: stack memory read, unit issue, write-back
//   DIV: read, issue, one quotient bit per cycle, sign fix-up, write-back
// A fault or HALT word leaves the output register the cycle after its byte
// is taken. The top of stack lives in a register; the rest of the stack is
// a single-port-write, registered-read memory that needs no clearing.
// After reset the block ignores bytes until one arrives with program_start.
// While the output word is stalled by the receiver the input is held off,
// unless the receiver takes the word in that same cycle.
module stack_bytecode_evaluator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       code_byte,
	input  logic                             program_start,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [sbe_pkg::DATA_W-1:0] value,
	output logic [2:0]                       status
);

	sbe_pkg::ctrl_state_t          state_q, state_d;
	logic [sbe_pkg::CNT_W-1:0]     count_q, count_d, eff_count;
	logic [2:0]                    left_q, left_d, eff_left;
	logic                          disc_q, disc_d, eff_disc;
	logic [sbe_pkg::DATA_W-1:0]    lit_q, lit_d;
	logic [sbe_pkg::DATA_W-1:0]    tos_q, tos_d;
	logic                          tos_we;
	sbe_pkg::alu_op_t              op_q, op_d;
	logic                          pop_q, pop_d;
	logic                          out_valid_q;
	logic [sbe_pkg::DATA_W-1:0]    value_q;
	sbe_pkg::status_t              status_q;
	logic                          accept;
	logic                          emit;
	sbe_pkg::status_t              emit_status;
	logic [sbe_pkg::DATA_W-1:0]    emit_value;
	logic                          mem_we;
	logic [sbe_pkg::CNT_W-1:0]     cnt_m1, cnt_m2;
	logic [sbe_pkg::PTR_W-1:0]     waddr, raddr;
	logic [sbe_pkg::DATA_W-1:0]    mem [sbe_pkg::STACK_DEPTH];
	logic [sbe_pkg::DATA_W-1:0]    rd_data_q;
	sbe_pkg::alu_req_t             alu_req;
	sbe_pkg::alu_rsp_t             alu_rsp;

	// handshakes
	assign in_ready  = (state_q == sbe_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// program start clears stack, literal collection and discard state
	assign eff_count = program_start ? '0 : count_q;
	assign eff_left  = program_start ? 3'd0 : left_q;
	assign eff_disc  = program_start ? 1'b0 : disc_q;

	// stack memory addresses below the top of stack
	assign cnt_m1 = eff_count - sbe_pkg::CNT_W'(1);
	assign cnt_m2 = eff_count - sbe_pkg::CNT_W'(2);
	assign waddr  = cnt_m1[sbe_pkg::PTR_W-1:0];
	assign raddr  = cnt_m2[sbe_pkg::PTR_W-1:0];

	// next state, decode and unit requests
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		left_d      = left_q;
		disc_d      = disc_q;
		lit_d       = lit_q;
		tos_d       = alu_rsp.result;
		tos_we      = 1'b0;
		op_d        = op_q;
		pop_d       = pop_q;
		mem_we      = 1'b0;
		emit        = 1'b0;
		emit_status = sbe_pkg::ST_OK;
		emit_value  = '0;
		alu_req     = '0;
		case (state_q)
			sbe_pkg::S_IDLE: begin
				if (accept) begin
					count_d = eff_count;
					left_d  = eff_left;
					disc_d  = eff_disc;
					if (!eff_disc) begin
						if (eff_left != 3'd0) begin
							// collect a literal byte, little-endian
							lit_d  = {code_byte, lit_q[sbe_pkg::DATA_W-1:8]};
							left_d = eff_left - 3'd1;
							if (eff_left == 3'd1) begin
								tos_we  = 1'b1;
								tos_d   = lit_d;
								count_d = eff_count + sbe_pkg::CNT_W'(1);
								mem_we  = (eff_count != '0);
							end
						end else begin
							case (code_byte)
								sbe_pkg::OP_HALT: begin
									emit = 1'b1;
									if (eff_count == sbe_pkg::CNT_W'(1)) begin
										emit_value = tos_q;
									end else begin
										emit_status = sbe_pkg::ST_UNBALANCED;
									end
								end
								sbe_pkg::OP_ADD, sbe_pkg::OP_SUB,
								sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
									if (eff_count < sbe_pkg::CNT_W'(2)) begin
										emit        = 1'b1;
										emit_status = sbe_pkg::ST_UNDERFLOW;
									end else if (code_byte == sbe_pkg::OP_DIV && tos_q == '0) begin
										emit        = 1'b1;
										emit_status = sbe_pkg::ST_DIVZERO;
									end else begin
										pop_d   = 1'b1;
										state_d = sbe_pkg::S_FETCH;
										case (code_byte)
											sbe_pkg::OP_ADD: op_d = sbe_pkg::ALU_ADD;
											sbe_pkg::OP_SUB: op_d = sbe_pkg::ALU_SUB;
											sbe_pkg::OP_MUL: op_d = sbe_pkg::ALU_MUL;
											default:         op_d = sbe_pkg::ALU_DIV;
										endcase
									end
								end
								sbe_pkg::OP_NEG: begin
									if (eff_count == '0) begin
										emit        = 1'b1;
										emit_status = sbe_pkg::ST_UNDERFLOW;
									end else begin
										// negate as zero minus top of stack
										alu_req.start = 1'b1;
										alu_req.op    = sbe_pkg::ALU_SUB;
										alu_req.a     = '0;
										alu_req.b     = tos_q;
										pop_d         = 1'b0;
										state_d       = sbe_pkg::S_ALU;
									end
								end
								sbe_pkg::OP_LIT: begin
									if (eff_count >= sbe_pkg::CNT_W'(sbe_pkg::STACK_DEPTH)) begin
										emit        = 1'b1;
										emit_status = sbe_pkg::ST_OVERFLOW;
									end else begin
										left_d = sbe_pkg::LIT_BYTES;
										lit_d  = '0;
									end
								end
								default: begin
									emit        = 1'b1;
									emit_status = sbe_pkg::ST_ILLEGAL;
								end
							endcase
							if (emit) begin
								disc_d = 1'b1;
							end
						end
					end
				end
			end
			sbe_pkg::S_FETCH: begin
				// second operand is now out of the stack memory
				alu_req.start = 1'b1;
				alu_req.op    = op_q;
				alu_req.a     = rd_data_q;
				alu_req.b     = tos_q;
				state_d       = sbe_pkg::S_ALU;
			end
			sbe_pkg::S_ALU: begin
				if (alu_rsp.done) begin
					tos_we  = 1'b1;
					tos_d   = alu_rsp.result;
					state_d = sbe_pkg::S_IDLE;
					if (pop_q) begin
						count_d = count_q - sbe_pkg::CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = sbe_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbe_pkg::S_IDLE;
			count_q     <= '0;
			left_q      <= 3'd0;
			disc_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			disc_q  <= disc_d;
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lit_q <= lit_d;
		op_q  <= op_d;
		pop_q <= pop_d;
		if (tos_we) begin
			tos_q <= tos_d;
		end
		if (accept && emit) begin
			value_q  <= emit_value;
			status_q <= emit_status;
		end
	end

	// stack memory below the top of stack
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= tos_q;
		end
		if (accept) begin
			rd_data_q <= mem[raddr];
		end
	end

	sbe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// unit completes only while the sequencer waits for it
	a_done_in_alu: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == sbe_pkg::S_ALU)
		else $error("arithmetic unit finished outside its wait state");

	// stack occupancy stays within depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sbe_pkg::CNT_W'(sbe_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	// an emitted word is presented and the block then discards
	a_emit_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (out_valid_q && disc_q))
		else $error("emitted word not presented or discard not set");

	// operand fetch always hands over to the unit
	a_fetch_to_alu: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbe_pkg::S_FETCH |=> state_q == sbe_pkg::S_ALU)
		else $error("operand fetch not followed by unit issue");

endmodule

// ===== verif/stack_bytecode_evaluator_unit_test.sv =====
// self-checking testbench for the stack bytecode evaluator: bytecode programs in, results checked
module stack_bytecode_evaluator_unit_test;

	localparam int CLK_PERIOD   = 20;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [7:0] code;
		logic       first;
	} code_word_t;

	typedef struct packed {
		logic [sbe_pkg::DATA_W-1:0] value;
		sbe_pkg::status_t           status;
	} eval_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        code_byte = 8'd0;
	logic              program_start = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [sbe_pkg::DATA_W-1:0] value;
	logic [2:0]        status;

	stack_bytecode_evaluator_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_byte     (code_byte),
		.program_start (program_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.value         (value),
		.status        (status)
	);

	// words waiting to be sent and results waiting to arrive
	code_word_t   code_words[$];
	eval_result_t results_due[$];

	int send_idle_pct = 32;
	int recv_idle_pct = 80;
	int fails = 0;
	int words_taken = 0;
	int results_seen = 0;
	int results_ok = 0;
	int words_queued = 0;
	bit next_is_first = 1'b0;

	// evaluator state mirrored on the testbench side
	logic [sbe_pkg::DATA_W-1:0] eval_stack[sbe_pkg::STACK_DEPTH];
	int                eval_depth = 0;
	logic [sbe_pkg::DATA_W-1:0] lit_acc = '0;
	int                lit_left = 0;
	bit                skipping = 1'b1;

	// clock and the single reset
	initial begin
		fork
			forever #(CLK_PERIOD / 2) clk = ~clk;
			begin
				repeat (6) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("TEST FAILED");
		$finish;
	end

	// evaluate one accepted word, returning the result it causes if any
	function automatic void eval_word(input logic [7:0] b, input logic first,
			output bit emitted, output eval_result_t res);
		logic [sbe_pkg::DATA_W-1:0] x, y, r;
		emitted = 1'b0;
		res.value = '0;
		res.status = sbe_pkg::ST_OK;
		r = '0;
		if (first) begin
			eval_depth = 0;
			lit_acc = '0;
			lit_left = 0;
			skipping = 1'b0;
		end
		if (skipping)
			return;
		// literal collection, low byte first
		if (lit_left != 0) begin
			lit_acc = {b, lit_acc[sbe_pkg::DATA_W-1:8]};
			lit_left--;
			if (lit_left == 0 && eval_depth < sbe_pkg::STACK_DEPTH) begin
				eval_stack[eval_depth] = lit_acc;
				eval_depth++;
			end
			return;
		end
		emitted = 1'b1;
		case (b)
			sbe_pkg::OP_HALT: begin
				if (eval_depth == 1)
					res.value = eval_stack[0];
				else
					res.status = sbe_pkg::ST_UNBALANCED;
			end
			sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
				if (eval_depth < 2) begin
					res.status = sbe_pkg::ST_UNDERFLOW;
				end else begin
					y = eval_stack[eval_depth - 1];
					x = eval_stack[eval_depth - 2];
					if (b == sbe_pkg::OP_DIV && y == '0) begin
						res.status = sbe_pkg::ST_DIVZERO;
					end else begin
						case (b)
							sbe_pkg::OP_ADD: r = x + y;
							sbe_pkg::OP_SUB: r = x - y;
							sbe_pkg::OP_MUL: r = x * y;
							default: begin
								// minus one handled apart so the most negative value wraps
								if (y == '1)
									r = '0 - x;
								else
									r = $signed(x) / $signed(y);
							end
						endcase
						eval_depth--;
						eval_stack[eval_depth - 1] = r;
						emitted = 1'b0;
					end
				end
			end
			sbe_pkg::OP_NEG: begin
				if (eval_depth < 1) begin
					res.status = sbe_pkg::ST_UNDERFLOW;
				end else begin
					eval_stack[eval_depth - 1] = '0 - eval_stack[eval_depth - 1];
					emitted = 1'b0;
				end
			end
			sbe_pkg::OP_LIT: begin
				if (eval_depth >= sbe_pkg::STACK_DEPTH) begin
					res.status = sbe_pkg::ST_OVERFLOW;
				end else begin
					lit_acc = '0;
					lit_left = sbe_pkg::LIT_BYTES;
					emitted = 1'b0;
				end
			end
			default: res.status = sbe_pkg::ST_ILLEGAL;
		endcase
		if (emitted)
			skipping = 1'b1;
	endfunction

	// driver: take words from the queue, hold each until accepted
	always @(posedge clk) begin : drive
		code_word_t   w;
		eval_result_t res;
		bit           emitted;
		if (in_valid && in_ready) begin
			eval_word(code_byte, program_start, emitted, res);
			if (emitted)
				results_due.insert(results_due.size(), res);
			words_taken++;
		end
		if (arst_n && !(in_valid && !in_ready)) begin
			if (code_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = code_words.pop_front();
				in_valid <= 1'b1;
				code_byte <= w.code;
				program_start <= w.first;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin : watch
		eval_result_t e;
		if (out_valid && out_ready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$error("result word with nothing expected: value %0d status %0d", value, status);
				fails++;
			end else begin
				e = results_due.pop_front();
				if (e.status == sbe_pkg::ST_OK)
					results_ok++;
				if (value !== e.value) begin
					$error("value mismatch: expected %0d, got %0d", $signed(e.value), value);
					fails++;
				end
				if (status !== e.status) begin
					$error("status mismatch: expected %0d, got %0d", e.status, status);
					fails++;
				end
			end
		end
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// stimulus helpers
	task automatic put_op(input logic [7:0] code);
		code_word_t w;
		w.code = code;
		w.first = next_is_first;
		next_is_first = 1'b0;
		code_words.insert(code_words.size(), w);
		words_queued++;
	endtask

	task automatic put_raw(input logic [7:0] code, input logic first);
		code_word_t w;
		w.code = code;
		w.first = first;
		code_words.insert(code_words.size(), w);
	endtask

	task automatic put_lit(input logic [sbe_pkg::DATA_W-1:0] v);
		put_op(sbe_pkg::OP_LIT);
		put_op(v[7:0]);
		put_op(v[15:8]);
		put_op(v[23:16]);
		put_op(v[31:24]);
	endtask

	function automatic logic [sbe_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'd1;
			5: return $urandom_range(2, 40);
			6: return '0 - $urandom_range(2, 40);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_binop();
		case ($urandom_range(11))
			0, 1, 2: return sbe_pkg::OP_ADD;
			3, 4, 5: return sbe_pkg::OP_SUB;
			6, 7, 8, 9: return sbe_pkg::OP_MUL;
			default: return sbe_pkg::OP_DIV;
		endcase
	endfunction

	// bytes after a program's last word, ignored until the next program start once a result has come
	task automatic put_tail();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) put_raw(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// mostly well-formed program with random content, some with a flaw
	task automatic gen_program();
		int flaw, steps, depth, i, k;
		flaw = $urandom_range(99);
		steps = $urandom_range(1, 10);
		depth = 0;
		next_is_first = 1'b1;
		// restart in the middle of a literal
		if (flaw >= 90 && flaw < 95) begin
			put_op(sbe_pkg::OP_LIT);
			k = $urandom_range(0, 3);
			repeat (k) put_op(8'($urandom_range(0, 255)));
			next_is_first = 1'b1;
		end
		for (i = 0; i < steps; i++) begin
			k = $urandom_range(9);
			if (depth == 0 || k < 4 || (depth < 2 && k != 4)) begin
				put_lit(pick_value());
				depth++;
			end else if (k == 4) begin
				put_op(sbe_pkg::OP_NEG);
			end else begin
				put_op(pick_binop());
				depth--;
			end
		end
		// restart while the program runs: next program takes over
		if (flaw >= 95)
			return;
		if (flaw < 85 || flaw >= 90) begin
			while (depth > 1) begin
				put_op(pick_binop());
				depth--;
			end
		end
		if (flaw >= 75 && flaw < 80)
			put_op(8'($urandom_range(7, 255)));
		else if (flaw >= 80 && flaw < 85)
			put_op(($urandom_range(1) == 0) ? sbe_pkg::OP_ADD : pick_binop());
		else
			put_op(sbe_pkg::OP_HALT);
		put_tail();
	endtask

	// fill the whole stack, then overflow or fold it back down
	task automatic gen_deep_program();
		int i;
		next_is_first = 1'b1;
		for (i = 0; i < sbe_pkg::STACK_DEPTH; i++)
			put_lit($urandom_range(0, 300) - 150);
		if ($urandom_range(1) == 0) begin
			put_op(sbe_pkg::OP_LIT);
			repeat (4) put_raw(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			for (i = 1; i < sbe_pkg::STACK_DEPTH; i++)
				put_op(($urandom_range(2) == 0) ? sbe_pkg::OP_SUB : sbe_pkg::OP_ADD);
			put_op(sbe_pkg::OP_HALT);
		end
	endtask

	// random bytes with random program starts
	task automatic gen_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			next_is_first = ($urandom_range(3) == 0);
			put_op(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic gen_random(input int target);
		int r;
		while (words_queued < target) begin
			r = $urandom_range(99);
			if (r < 2)
				gen_deep_program();
			else if (r < 12)
				gen_noise();
			else
				gen_program();
		end
	endtask

	task automatic wait_queue_empty();
		while (code_words.size() != 0)
			@(posedge clk);
	endtask

	// test sequence
	initial begin
		// ignored before any program start
		put_raw(8'hA5, 1'b0);
		// halt on an empty stack
		next_is_first = 1'b1;
		put_op(sbe_pkg::OP_HALT);
		// illegal opcode just past the last one
		next_is_first = 1'b1;
		put_op(8'd7);
		// underflow on a binary operator and on negation
		next_is_first = 1'b1;
		put_op(sbe_pkg::OP_ADD);
		next_is_first = 1'b1;
		put_op(sbe_pkg::OP_NEG);
		// most negative over minus one
		next_is_first = 1'b1;
		put_lit(32'h8000_0000);
		put_lit(32'hFFFF_FFFF);
		put_op(sbe_pkg::OP_DIV);
		put_op(sbe_pkg::OP_HALT);
		// restart inside a literal
		next_is_first = 1'b1;
		put_op(sbe_pkg::OP_LIT);
		put_op(8'h12);
		put_op(8'h34);
		next_is_first = 1'b1;
		put_op(sbe_pkg::OP_HALT);

		gen_random(620);
		wait_queue_empty();
		send_idle_pct = 80;
		recv_idle_pct = 32;
		gen_random(1240);
		wait_queue_empty();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_random(1850);

		// drain: every word sent and every result in, then a little longer
		while (code_words.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("fed %0d bytecode words under three idling mixes", words_taken);
		$display("checked %0d result words, %0d ok and %0d faults",
			results_seen, results_ok, results_seen - results_ok);
		if (fails == 0 && results_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
